// File: src/hsv2rgb_pkg.sv
// Shared constants, types and fixed-point widths of the HSV to RGB converter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package hsv2rgb_pkg;

	// Field widths and full scale of a channel (full scale means 1.0).
	localparam int CHANNEL_BITS = 8;
	localparam int HUE_BITS     = 16;
	localparam int CHAN_MAX     = (1 << CHANNEL_BITS) - 1;

	// Hue circle and sector size in degrees.
	localparam int HUE_MOD    = 360;
	localparam int SECTOR_DEG = 60;

	// Hue reduction: quotient estimate by reciprocal multiplication.
	localparam int     HQ_BITS    = $clog2((1 << HUE_BITS) / HUE_MOD + 1);
	localparam int     HUE_SHIFT  = HUE_BITS + HQ_BITS;
	localparam longint HUE_RECIP  = (longint'(1) << HUE_SHIFT) / HUE_MOD;
	localparam int     HUE_RW     = $clog2(HUE_RECIP + 1);
	localparam int     HPROD_BITS = HUE_BITS + HUE_RW;
	localparam int     HRAW_BITS  = $clog2(2 * HUE_MOD);
	localparam int     ANGLE_BITS = $clog2(HUE_MOD);
	localparam int     REM_BITS   = $clog2(SECTOR_DEG);
	localparam int     SPAN_BITS  = $clog2(SECTOR_DEG + 1);

	// p = floor(V * (M - S) / M): divide by full scale through a reciprocal.
	localparam int     PX_BITS    = 2 * CHANNEL_BITS;
	localparam longint P_RECIP    = (longint'(1) << PX_BITS) / CHAN_MAX;
	localparam int     P_RW       = $clog2(P_RECIP + 1);
	localparam int     PPROD_BITS = PX_BITS + P_RW;

	// q and t: divide by 60 * M through a reciprocal.
	localparam int     QDEN       = SECTOR_DEG * CHAN_MAX;
	localparam int     QN_BITS    = $clog2(QDEN + 1);
	localparam int     QX_BITS    = CHANNEL_BITS + QN_BITS;
	localparam longint Q_RECIP    = (longint'(1) << QX_BITS) / QDEN;
	localparam int     Q_RW       = $clog2(Q_RECIP + 1);
	localparam int     QPROD_BITS = QX_BITS + Q_RW;

	// Number of register stages from input to output register.
	localparam int STAGES = 8;

	// Hue sector, named after the color at its start.
	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	// Per-stage load enables and valid bits of the pipeline.
	typedef struct packed {
		logic [STAGES-1:0] en;
		logic [STAGES-1:0] vld;
	} pipe_ctl_t;

endpackage

`default_nettype wire

// File: src/hsv2rgb_hsv_if.sv
// Input channel of the converter: one HSV color word with valid/ready.
// Depends on hsv2rgb_pkg for the field widths.
`default_nettype none

interface hsv2rgb_hsv_if
	import hsv2rgb_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic [HUE_BITS-1:0]     hue;
	logic [CHANNEL_BITS-1:0] saturation;
	logic [CHANNEL_BITS-1:0] brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

`default_nettype wire

// File: src/hsv2rgb_rgb_if.sv
// Output channel of the converter: one RGB color word with valid/ready.
// Depends on hsv2rgb_pkg for the field widths.
`default_nettype none

interface hsv2rgb_rgb_if
	import hsv2rgb_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// File: src/hsv2rgb_ctrl.sv
// Pipeline control: valid bits of every stage and the per-stage load enables.
// Depends on hsv2rgb_pkg for the stage count and the control struct.
`default_nettype none

module hsv2rgb_ctrl
	import hsv2rgb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      out_ready,
	output pipe_ctl_t      ctl
);

	logic [STAGES-1:0] vld_q;
	logic [STAGES:0]   go;

	// A stage may load when it is empty or when the stage after it moves on.
	always_comb begin
		go[STAGES] = out_ready;
		for (int k = STAGES - 1; k >= 0; k--) begin
			go[k] = !vld_q[k] || go[k+1];
		end
	end

	assign ctl.en  = go[STAGES-1:0];
	assign ctl.vld = vld_q;

	// Valid bits move with the data of their stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (go[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (go[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: src/hsv2rgb_hue.sv
// Hue path: reduces the hue modulo 360 and splits it into sector and remainder.
// Depends on hsv2rgb_pkg; occupies pipeline stages one to three.
`default_nettype none

module hsv2rgb_hue
	import hsv2rgb_pkg::*;
(
	input  wire logic                clk,
	input  wire pipe_ctl_t           ctl,
	input  wire logic [HUE_BITS-1:0] hue,
	output sector_t                  sector_s3,
	output logic [REM_BITS-1:0]      rem_s3
);

	logic [HPROD_BITS-1:0] hprod;
	logic [HUE_BITS-1:0]   hue_s1;
	logic [HQ_BITS-1:0]    hq_s1;
	logic [HUE_BITS-1:0]   hq_mul;
	logic [HRAW_BITS-1:0]  h_raw;
	logic [ANGLE_BITS-1:0] h_fix;
	logic [ANGLE_BITS-1:0] h_s2;
	sector_t               sector_c;
	logic [ANGLE_BITS-1:0] base_c;

	// Stage 1: quotient estimate hue / 360, low by at most one.
	assign hprod = HPROD_BITS'(hue) * HPROD_BITS'(HUE_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			hue_s1 <= hue;
			hq_s1  <= hprod[HUE_SHIFT +: HQ_BITS];
		end
	end

	// Stage 2: remainder, corrected once when the estimate fell short.
	assign hq_mul = HUE_BITS'(hq_s1) * HUE_BITS'(HUE_MOD);
	assign h_raw  = HRAW_BITS'(hue_s1 - hq_mul);
	assign h_fix  = (h_raw >= HRAW_BITS'(HUE_MOD)) ?
		ANGLE_BITS'(h_raw - HRAW_BITS'(HUE_MOD)) : ANGLE_BITS'(h_raw);

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			h_s2 <= h_fix;
		end
	end

	// Stage 3: sector by a compare ladder, then the angle inside the sector.
	always_comb begin
		priority if (h_s2 >= ANGLE_BITS'(5 * SECTOR_DEG)) begin
			sector_c = SEC_MAGENTA;
			base_c   = ANGLE_BITS'(5 * SECTOR_DEG);
		end else if (h_s2 >= ANGLE_BITS'(4 * SECTOR_DEG)) begin
			sector_c = SEC_BLUE;
			base_c   = ANGLE_BITS'(4 * SECTOR_DEG);
		end else if (h_s2 >= ANGLE_BITS'(3 * SECTOR_DEG)) begin
			sector_c = SEC_CYAN;
			base_c   = ANGLE_BITS'(3 * SECTOR_DEG);
		end else if (h_s2 >= ANGLE_BITS'(2 * SECTOR_DEG)) begin
			sector_c = SEC_GREEN;
			base_c   = ANGLE_BITS'(2 * SECTOR_DEG);
		end else if (h_s2 >= ANGLE_BITS'(SECTOR_DEG)) begin
			sector_c = SEC_YELLOW;
			base_c   = ANGLE_BITS'(SECTOR_DEG);
		end else begin
			sector_c = SEC_RED;
			base_c   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			sector_s3 <= sector_c;
			rem_s3    <= REM_BITS'(h_s2 - base_c);
		end
	end

endmodule

`default_nettype wire

// File: src/hsv2rgb_chan.sv
// Channel path: computes p, q and t from saturation, value and hue remainder.
// Depends on hsv2rgb_pkg; occupies pipeline stages one to seven.
`default_nettype none

module hsv2rgb_chan
	import hsv2rgb_pkg::*;
(
	input  wire logic                    clk,
	input  wire pipe_ctl_t               ctl,
	input  wire logic [CHANNEL_BITS-1:0] saturation,
	input  wire logic [CHANNEL_BITS-1:0] brightness,
	input  wire sector_t                 sector_s3,
	input  wire logic [REM_BITS-1:0]     rem_s3,
	output sector_t                      sector_s7,
	output logic [CHANNEL_BITS-1:0]      v_s7,
	output logic [CHANNEL_BITS-1:0]      p_s7,
	output logic [CHANNEL_BITS-1:0]      q_s7,
	output logic [CHANNEL_BITS-1:0]      t_s7
);

	logic [CHANNEL_BITS-1:0] s_s1, s_s2, s_s3;
	logic [CHANNEL_BITS-1:0] v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [PX_BITS-1:0]      px_s1, px_s2;
	logic [PPROD_BITS-1:0]   pprod;
	logic [CHANNEL_BITS-1:0] pe_s2;
	logic [PX_BITS-1:0]      pback;
	logic [PX_BITS-1:0]      prem;
	logic [CHANNEL_BITS-1:0] p_s3, p_s4, p_s5, p_s6;
	sector_t                 sector_s4, sector_s5, sector_s6;
	logic [SPAN_BITS-1:0]    span;
	logic [QN_BITS-1:0]      qn_s4, tn_s4;
	logic [QX_BITS-1:0]      qx_s5, tx_s5, qx_s6, tx_s6;
	logic [QPROD_BITS-1:0]   qprod, tprod;
	logic [CHANNEL_BITS-1:0] qe_s6, te_s6;
	logic [QX_BITS-1:0]      qrem, trem;

	// Stage 1: numerator of p, V * (M - S).
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			s_s1  <= saturation;
			v_s1  <= brightness;
			px_s1 <= PX_BITS'(brightness) *
				PX_BITS'(CHANNEL_BITS'(CHAN_MAX) - saturation);
		end
	end

	// Stage 2: estimate of p, low by at most one.
	assign pprod = PPROD_BITS'(px_s1) * PPROD_BITS'(P_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			s_s2  <= s_s1;
			v_s2  <= v_s1;
			px_s2 <= px_s1;
			pe_s2 <= pprod[PX_BITS +: CHANNEL_BITS];
		end
	end

	// Stage 3: correct p when the remainder reaches full scale.
	assign pback = PX_BITS'(pe_s2) * PX_BITS'(CHAN_MAX);
	assign prem  = px_s2 - pback;

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			s_s3 <= s_s2;
			v_s3 <= v_s2;
			p_s3 <= (prem >= PX_BITS'(CHAN_MAX)) ? pe_s2 + 1'b1 : pe_s2;
		end
	end

	// Stage 4: numerators 60M - S*r and 60M - S*(60 - r).
	assign span = SPAN_BITS'(SECTOR_DEG) - SPAN_BITS'(rem_s3);

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			sector_s4 <= sector_s3;
			v_s4      <= v_s3;
			p_s4      <= p_s3;
			qn_s4     <= QN_BITS'(QDEN) - QN_BITS'(s_s3) * QN_BITS'(rem_s3);
			tn_s4     <= QN_BITS'(QDEN) - QN_BITS'(s_s3) * QN_BITS'(span);
		end
	end

	// Stage 5: scale the numerators by V.
	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			sector_s5 <= sector_s4;
			v_s5      <= v_s4;
			p_s5      <= p_s4;
			qx_s5     <= QX_BITS'(v_s4) * QX_BITS'(qn_s4);
			tx_s5     <= QX_BITS'(v_s4) * QX_BITS'(tn_s4);
		end
	end

	// Stage 6: estimates of q and t, each low by at most one.
	assign qprod = QPROD_BITS'(qx_s5) * QPROD_BITS'(Q_RECIP);
	assign tprod = QPROD_BITS'(tx_s5) * QPROD_BITS'(Q_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			sector_s6 <= sector_s5;
			v_s6      <= v_s5;
			p_s6      <= p_s5;
			qx_s6     <= qx_s5;
			tx_s6     <= tx_s5;
			qe_s6     <= qprod[QX_BITS +: CHANNEL_BITS];
			te_s6     <= tprod[QX_BITS +: CHANNEL_BITS];
		end
	end

	// Stage 7: correct q and t when the remainder reaches 60M.
	assign qrem = qx_s6 - QX_BITS'(qe_s6) * QX_BITS'(QDEN);
	assign trem = tx_s6 - QX_BITS'(te_s6) * QX_BITS'(QDEN);

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			sector_s7 <= sector_s6;
			v_s7      <= v_s6;
			p_s7      <= p_s6;
			q_s7      <= (qrem >= QX_BITS'(QDEN)) ? qe_s6 + 1'b1 : qe_s6;
			t_s7      <= (trem >= QX_BITS'(QDEN)) ? te_s6 + 1'b1 : te_s6;
		end
	end

endmodule

`default_nettype wire

// File: src/hsv_to_rgb_converter.sv
// HSV to RGB converter: the hsv input word comes out as one rgb output word.
//
// Channels: hsv (sink) carries hue in whole degrees, taken modulo 360, and
// saturation and brightness as fractions where 255 means 1.0. rgb (source)
// carries red, green and blue, each the exact result truncated toward zero.
// A word moves on a channel at a rising edge of clk with valid and ready high.
// An accepted hsv word passes every register stage, the output register last.
// Throughput is one word per cycle unless rgb stalls; the stage count is set
// by the chained multiplications for q and t, each followed by a register.
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves on, so bubbles close up while rgb is stalled and the
// input keeps taking words until the pipeline is full. Nothing is dropped or
// repeated during a stall; the rgb word holds until it is taken.
// Reset (arst_n low) empties the pipeline at once; there is no other state.
// Depends on hsv2rgb_pkg, the two channel interfaces, hsv2rgb_ctrl,
// hsv2rgb_hue and hsv2rgb_chan.
`default_nettype none

module hsv_to_rgb_converter
	import hsv2rgb_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	hsv2rgb_hsv_if.sink  hsv,
	hsv2rgb_rgb_if.source rgb
);

	pipe_ctl_t               ctl;
	sector_t                 sector_s3, sector_s7;
	logic [REM_BITS-1:0]     rem_s3;
	logic [CHANNEL_BITS-1:0] v_s7, p_s7, q_s7, t_s7;
	logic [CHANNEL_BITS-1:0] red_c, green_c, blue_c;
	logic [CHANNEL_BITS-1:0] red_s8, green_s8, blue_s8;

	// Valid bits and stage enables.
	hsv2rgb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hsv.valid),
		.out_ready (rgb.ready),
		.ctl       (ctl)
	);

	assign hsv.ready = ctl.en[0];

	// Hue reduction and sector split.
	hsv2rgb_hue u_hue (
		.clk       (clk),
		.ctl       (ctl),
		.hue       (hsv.hue),
		.sector_s3 (sector_s3),
		.rem_s3    (rem_s3)
	);

	// p, q and t arithmetic.
	hsv2rgb_chan u_chan (
		.clk        (clk),
		.ctl        (ctl),
		.saturation (hsv.saturation),
		.brightness (hsv.brightness),
		.sector_s3  (sector_s3),
		.rem_s3     (rem_s3),
		.sector_s7  (sector_s7),
		.v_s7       (v_s7),
		.p_s7       (p_s7),
		.q_s7       (q_s7),
		.t_s7       (t_s7)
	);

	// Route v, p, q and t to the three channels by sector.
	always_comb begin
		unique case (sector_s7)
			SEC_RED: begin
				red_c = v_s7; green_c = t_s7; blue_c = p_s7;
			end
			SEC_YELLOW: begin
				red_c = q_s7; green_c = v_s7; blue_c = p_s7;
			end
			SEC_GREEN: begin
				red_c = p_s7; green_c = v_s7; blue_c = t_s7;
			end
			SEC_CYAN: begin
				red_c = p_s7; green_c = q_s7; blue_c = v_s7;
			end
			SEC_BLUE: begin
				red_c = t_s7; green_c = p_s7; blue_c = v_s7;
			end
			default: begin
				red_c = v_s7; green_c = p_s7; blue_c = q_s7;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			red_s8   <= red_c;
			green_s8 <= green_c;
			blue_s8  <= blue_c;
		end
	end

	assign rgb.valid = ctl.vld[7];
	assign rgb.red   = red_s8;
	assign rgb.green = green_s8;
	assign rgb.blue  = blue_s8;

endmodule

`default_nettype wire
